// ===== hw/rtl/fnof_pkg.sv =====
// Shared types, constants and register codes of the four-neighbor outlier filter.
package fnof_pkg;

    localparam int PIX_W      = 8;
    localparam int COL_W      = 6;
    localparam int ROW_W      = 12;
    localparam int THR_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int MAX_WIDTH_DEF   = 32;
    localparam int IN_QUEUE_DEPTH  = 4;
    localparam int OUT_QUEUE_DEPTH = 2;

    localparam logic [COL_W-1:0] WIDTH_RESET     = 6'd30;
    localparam logic [ROW_W-1:0] HEIGHT_RESET    = 12'd20;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd1;

    // Smallest frame dimension in use
    localparam int MIN_DIM = 2;

    // Neighbor counts and the reciprocal used for the mean of three
    localparam logic [2:0] NB_TWO   = 3'd2;
    localparam logic [2:0] NB_THREE = 3'd3;
    localparam logic [2:0] NB_FOUR  = 3'd4;
    localparam int RECIP3       = 683;
    localparam int RECIP3_SHIFT = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH     = 2'd0,
        REG_IMAGE_HEIGHT    = 2'd1,
        REG_NOISE_THRESHOLD = 2'd2
    } reg_index_t;

    // Pixel tagged with its place in the frame
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] col;
        logic             emit;
        logic             has_up;
        logic             has_right;
        logic             row_end;
        logic             frame_end;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             replaced;
        logic             frame_done;
        logic             run_last;
    } result_t;

endpackage

// ===== hw/rtl/fnof_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fnof_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/fnof_fifo.sv =====
// Small first-word-fall-through queue used on both sides of the filter core.
module fnof_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/fnof_front.sv =====
// Front end: tracks the raster position and tags each accepted pixel.
module fnof_front #(
    parameter int MAX_WIDTH = fnof_pkg::MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [fnof_pkg::PIX_W-1:0]   pixel_in,
    input  logic [fnof_pkg::COL_W-1:0]   image_width,
    input  logic [fnof_pkg::ROW_W-1:0]   image_height,
    output fnof_pkg::item_t              item,
    output logic [fnof_pkg::COL_W-1:0]   width_eff
);

    localparam int CW = fnof_pkg::COL_W;
    localparam int RW = fnof_pkg::ROW_W;
    localparam logic [CW-1:0] W_MAX = CW'(MAX_WIDTH);
    localparam logic [CW-1:0] W_MIN = CW'(fnof_pkg::MIN_DIM);
    localparam logic [RW-1:0] H_MIN = RW'(fnof_pkg::MIN_DIM);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [RW-1:0] height_eff;
    logic [CW:0]   col_inc;
    logic [RW:0]   row_inc;
    logic          row_end, last_row;

    // Clamp the width to what the line buffers can hold, and both sizes to the minimum
    always_comb
    begin
        if (image_width < W_MIN)
        begin
            width_eff = W_MIN;
        end
        else if (image_width > W_MAX)
        begin
            width_eff = W_MAX;
        end
        else
        begin
            width_eff = image_width;
        end
        height_eff = (image_height < H_MIN) ? H_MIN : image_height;
    end

    assign col_inc  = {1'b0, col_reg} + (CW + 1)'(1);
    assign row_inc  = {1'b0, row_reg} + (RW + 1)'(1);
    assign row_end  = (col_inc >= {1'b0, width_eff});
    assign last_row = (row_inc >= {1'b0, height_eff});

    always_comb
    begin
        item.pixel     = pixel_in;
        item.col       = col_reg;
        item.emit      = (row_reg != '0);
        item.has_up    = (row_reg[RW-1:1] != '0);
        item.has_right = !row_end;
        item.row_end   = row_end;
        item.frame_end = row_end && last_row;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (!row_end)
            begin
                col_next = col_inc[CW-1:0];
            end
            else
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc[RW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== hw/rtl/fnof_back.sv =====
// Back end: line buffer window, neighbor test and end-of-frame row sweep.
module fnof_back #(
    parameter int MAX_WIDTH = fnof_pkg::MAX_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  fnof_pkg::item_t             item,
    output logic                        item_pop,
    input  logic [fnof_pkg::COL_W-1:0]  width_eff,
    input  logic [fnof_pkg::THR_W-1:0]  noise_threshold,
    input  logic                        res_full,
    output logic                        res_push,
    output fnof_pkg::result_t           res
);

    localparam int PW = fnof_pkg::PIX_W;
    localparam int CW = fnof_pkg::COL_W;
    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [CW:0] DEPTH_LIM = (CW + 1)'(MAX_WIDTH);

    typedef enum logic [1:0] {
        ST_LOAD0,
        ST_LOAD1,
        ST_RUN,
        ST_FLUSH
    } state_t;

    state_t          state_reg, state_next;
    logic            flush_reg, flush_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [2*PW-1:0] ctr_reg, ctr_next;
    logic [PW-1:0]   left_reg, left_next;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [2*PW-1:0] ram_wdata, ram_rdata;

    logic [PW-1:0]   ctr_cur, ctr_up, right_px;
    logic [CW:0]     col_nxt2, j_inc, j_nxt2;
    logic            j_last;
    logic [PW:0]     run_judge, flush_judge;

    // Each buffer entry packs {current row pixel, row above pixel}
    fnof_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result is {replaced, pixel}; nb and has list up, down, left, right from the low end
    function automatic logic [PW:0] judge(
        input logic [PW-1:0]   center,
        input logic [4*PW-1:0] nb,
        input logic [3:0]      has,
        input logic [fnof_pkg::THR_W-1:0] thr
    );
        logic [PW-1:0]  v;
        logic [PW-1:0]  d;
        logic           far;
        logic [PW+1:0]  sum;
        logic [2:0]     cnt;
        logic [PW+11:0] prod;
        logic [PW-1:0]  mean;
        far = 1'b1;
        sum = '0;
        cnt = '0;
        for (int k = 0; k < 4; k++)
        begin
            v = nb[k*PW +: PW];
            d = (center > v) ? center - v : v - center;
            if (has[k])
            begin
                sum = sum + {2'b00, v};
                cnt = cnt + 3'd1;
                if (d <= thr)
                begin
                    far = 1'b0;
                end
            end
        end
        prod = (PW + 12)'(sum) * (PW + 12)'(fnof_pkg::RECIP3);
        case (cnt)
            fnof_pkg::NB_FOUR:  mean = sum[PW+1:2];
            fnof_pkg::NB_THREE: mean = prod[fnof_pkg::RECIP3_SHIFT +: PW];
            fnof_pkg::NB_TWO:   mean = sum[PW:1];
            default:            mean = sum[PW-1:0];
        endcase
        if (cnt == '0 || !far)
        begin
            return {1'b0, center};
        end
        return {1'b1, mean};
    endfunction

    assign ctr_cur  = ctr_reg[2*PW-1:PW];
    assign ctr_up   = ctr_reg[PW-1:0];
    assign right_px = ram_rdata[2*PW-1:PW];
    assign col_nxt2 = {1'b0, item.col} + (CW + 1)'(2);
    assign j_inc    = {1'b0, j_reg} + (CW + 1)'(1);
    assign j_nxt2   = {1'b0, j_reg} + (CW + 1)'(2);
    assign j_last   = (j_inc >= {1'b0, width_eff});

    assign run_judge = judge(ctr_cur,
                             {right_px, left_reg, item.pixel, ctr_up},
                             {item.has_right, (item.col != '0), 1'b1, item.has_up},
                             noise_threshold);

    assign flush_judge = judge(ctr_cur,
                               {right_px, left_reg, {PW{1'b0}}, ctr_up},
                               {!j_last, (j_reg != '0), 1'b0, 1'b1},
                               noise_threshold);

    always_comb
    begin
        state_next = state_reg;
        flush_next = flush_reg;
        j_next     = j_reg;
        ctr_next   = ctr_reg;
        left_next  = left_reg;
        item_pop   = 1'b0;
        res_push   = 1'b0;
        res        = '0;
        ram_we     = 1'b0;
        ram_waddr  = item.col[AW-1:0];
        ram_wdata  = {item.pixel, ctr_cur};
        ram_re     = 1'b0;
        ram_raddr  = '0;

        case (state_reg)
            ST_LOAD0:
            begin
                ram_re     = 1'b1;
                state_next = ST_LOAD1;
            end

            ST_LOAD1:
            begin
                // column 0 lands in the window, fetch column 1
                ctr_next   = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = AW'(1);
                j_next     = '0;
                state_next = flush_reg ? ST_FLUSH : ST_RUN;
            end

            ST_RUN:
            begin
                if (item_valid && !res_full)
                begin
                    item_pop = 1'b1;
                    ram_we   = 1'b1;
                    if (item.emit)
                    begin
                        res_push       = 1'b1;
                        res.pixel      = run_judge[PW-1:0];
                        res.replaced   = run_judge[PW];
                        res.frame_done = 1'b0;
                        res.run_last   = !item.frame_end;
                    end
                    left_next = ctr_cur;
                    ctr_next  = ram_rdata;
                    if (item.row_end)
                    begin
                        // restart the window at column 0
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        flush_next = item.frame_end;
                        state_next = ST_LOAD1;
                    end
                    else if (col_nxt2 < DEPTH_LIM)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = col_nxt2[AW-1:0];
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!res_full)
                begin
                    res_push       = 1'b1;
                    res.pixel      = flush_judge[PW-1:0];
                    res.replaced   = flush_judge[PW];
                    res.frame_done = j_last;
                    res.run_last   = j_last;
                    if (j_last)
                    begin
                        flush_next = 1'b0;
                        state_next = ST_LOAD0;
                    end
                    else
                    begin
                        left_next = ctr_cur;
                        ctr_next  = ram_rdata;
                        j_next    = j_inc[CW-1:0];
                        if (j_nxt2 < DEPTH_LIM)
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = j_nxt2[AW-1:0];
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD0;
            flush_reg <= 1'b0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctr_reg  <= ctr_next;
        left_reg <= left_next;
    end

endmodule

// ===== hw/rtl/four_neighbor_outlier_filter_unit.sv =====
// Top level of the four-neighbor impulse noise filter.
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  -----------------------------------------
//  pixel     in         push / full               pixel_in
//  result    out        empty / pop               pixel_out, was_replaced, frame_done, run_last
//  config    in         cfg_we (no wait)          cfg_index, cfg_data
//
//  Within a row the core takes one pixel per cycle while the result queue has
//  room; each row end passes through ST_LOAD1 to reload columns 0 and 1 of
//  the line buffer RAM. The last pixel of a frame adds a sweep over the last
//  row plus a reload through ST_LOAD0 and ST_LOAD1 before the next frame.
//  After reset the core primes the window in ST_LOAD0 and ST_LOAD1; line buffer
//  contents are undefined until written. A four-entry input queue absorbs
//  these bubbles, and a two-entry result queue lets results wait on pop
//  while new pixels are still taken.
module four_neighbor_outlier_filter_unit #(
    parameter int MAX_WIDTH = fnof_pkg::MAX_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [fnof_pkg::PIX_W-1:0]       pixel_in,
    output logic                             empty,
    input  logic                             pop,
    output logic [fnof_pkg::PIX_W-1:0]       pixel_out,
    output logic                             was_replaced,
    output logic                             frame_done,
    output logic                             run_last,
    input  logic                             cfg_we,
    input  logic [fnof_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fnof_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int ITEM_W = $bits(fnof_pkg::item_t);
    localparam int RES_W  = $bits(fnof_pkg::result_t);

    logic [fnof_pkg::COL_W-1:0] width_reg, width_next;
    logic [fnof_pkg::ROW_W-1:0] height_reg, height_next;
    logic [fnof_pkg::THR_W-1:0] thr_reg, thr_next;

    logic                        in_accept;
    fnof_pkg::item_t             front_item;
    fnof_pkg::item_t             queue_item;
    logic                        queue_empty;
    logic                        item_pop;
    logic [fnof_pkg::COL_W-1:0]  width_eff;
    logic                        res_full;
    logic                        res_push;
    fnof_pkg::result_t           back_res;
    fnof_pkg::result_t           out_res;

    // Configuration: take the write at once, ignore unknown indexes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        thr_next    = thr_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                fnof_pkg::REG_IMAGE_WIDTH:
                    width_next = cfg_data[fnof_pkg::COL_W-1:0];
                fnof_pkg::REG_IMAGE_HEIGHT:
                    height_next = cfg_data[fnof_pkg::ROW_W-1:0];
                fnof_pkg::REG_NOISE_THRESHOLD:
                    thr_next = cfg_data[fnof_pkg::THR_W-1:0];
                default:
                    width_next = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= fnof_pkg::WIDTH_RESET;
            height_reg <= fnof_pkg::HEIGHT_RESET;
            thr_reg    <= fnof_pkg::THRESHOLD_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            thr_reg    <= thr_next;
        end
    end

    // A pixel request is taken whenever the input queue has room
    assign in_accept = push && !full;

    // Front: tag each pixel with its frame position
    fnof_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .pixel_in     (pixel_in),
        .image_width  (width_reg),
        .image_height (height_reg),
        .item         (front_item),
        .width_eff    (width_eff)
    );

    // Decouple the front from the back so each side can stall on its own
    fnof_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (fnof_pkg::IN_QUEUE_DEPTH)
    ) u_in_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_accept),
        .wr_data (front_item),
        .full    (full),
        .rd_en   (item_pop),
        .rd_data (queue_item),
        .empty   (queue_empty)
    );

    // Back: line buffer window, neighbor test, last-row sweep
    fnof_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (!queue_empty),
        .item            (queue_item),
        .item_pop        (item_pop),
        .width_eff       (width_eff),
        .noise_threshold (thr_reg),
        .res_full        (res_full),
        .res_push        (res_push),
        .res             (back_res)
    );

    // Hold finished results until the consumer pops them
    fnof_fifo #(
        .WIDTH (RES_W),
        .DEPTH (fnof_pkg::OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

    assign pixel_out    = out_res.pixel;
    assign was_replaced = out_res.replaced;
    assign frame_done   = out_res.frame_done;
    assign run_last     = out_res.run_last;

endmodule

// ===== hw/rtl/fnof_checker.sv =====
// Port-level checks on the filter top level, attached by bind.
module fnof_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             push,
    input logic                             full,
    input logic                             empty,
    input logic                             pop,
    input logic [fnof_pkg::PIX_W-1:0]       pixel_out,
    input logic                             was_replaced,
    input logic                             frame_done,
    input logic                             run_last
);

    // Reset leaves both queues drained
    a_reset_drained: assert property (@(posedge clk)
        !rst_n |=> (!full && empty))
        else $error("queues not drained in reset");

    // The end of a frame always closes the run of its input
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_done) |-> run_last)
        else $error("frame_done without run_last");

    // Input queue fills only through a push request
    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a push");

    // Result queue drains only through a pop
    a_empty_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(empty) |-> $past(pop))
        else $error("empty rose without a pop");

    // A waiting result's pixel and replaced flag hold until taken
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pixel_out) && $stable(was_replaced)))
        else $error("waiting result changed");

endmodule

bind four_neighbor_outlier_filter_unit fnof_checker u_fnof_checker (.*);
